// ----- src/grl_pkg.sv -----
// Package with shared constants and types of the green light window detector.
`default_nettype none
package grl_pkg;

  localparam int unsigned DefMaxWidth  = 2048;
  localparam int unsigned DefMaxHeight = 2048;

  localparam int unsigned CountW   = 23;
  localparam int unsigned CfgDimW  = 12;
  localparam int unsigned RatioW   = 16;
  localparam int unsigned QueueDepth = 4;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_HUE_LOW      = 3'd2,
    REG_HUE_HIGH     = 3'd3,
    REG_SAT_LOW      = 3'd4,
    REG_VAL_LOW      = 3'd5,
    REG_RATIO        = 3'd6,
    REG_SPARE        = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_MUL,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [7:0] hue_low;
    logic [7:0] hue_high;
    logic [7:0] sat_low;
    logic [7:0] val_low;
  } thr_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       in_win;
    logic       last;
  } pix_t;

  typedef struct packed {
    logic              detected;
    logic [CountW-1:0] green_count;
    logic [CountW-1:0] window_pixels;
  } res_t;

endpackage
`default_nettype wire

// ----- src/grl_fifo.sv -----
// Short register queue between the front and the back part.
`default_nettype none
module grl_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule
`default_nettype wire

// ----- src/grl_front.sv -----
// Front part: accepts pixels, tracks column and row and marks window pixels.
`default_nettype none
module grl_front #(
  parameter int unsigned MaxWidth  = grl_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = grl_pkg::DefMaxHeight,
  localparam int unsigned WW = $clog2(MaxWidth) + 1,
  localparam int unsigned HW = $clog2(MaxHeight) + 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire logic [7:0]    blue_i,
  input  wire logic [7:0]    green_i,
  input  wire logic [7:0]    red_i,
  input  wire logic          last_i,
  input  wire logic [WW-1:0] width_i,
  input  wire logic [WW-1:0] win_x_i,
  input  wire logic [HW-1:0] win_h_i,
  output logic               push_o,
  output grl_pkg::pix_t      pix_o,
  input  wire logic          full_i
);
  import grl_pkg::*;

  localparam int unsigned CW = $clog2(MaxWidth);
  localparam int unsigned RW = $clog2(MaxHeight);

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          take;

  assign ready_o = !full_i;
  assign take    = valid_i && ready_o;
  assign push_o  = take;

  always_comb begin
    pix_o.blue   = blue_i;
    pix_o.green  = green_i;
    pix_o.red    = red_i;
    pix_o.last   = last_i;
    pix_o.in_win = ({1'b0, col_q} >= win_x_i) && ({1'b0, col_q} < width_i) &&
                   ({1'b0, row_q} < win_h_i);
    col_d = col_q;
    row_d = row_q;
    if (take) begin
      if (last_i) begin
        col_d = '0;
        row_d = '0;
      end else if (({1'b0, col_q} + 1'b1) >= width_i) begin
        col_d = '0;
        if (row_q != RW'(MaxHeight - 1)) begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end
endmodule
`default_nettype wire

// ----- src/grl_back.sv -----
// Back part: HSV classification, green count and frame result register.
`default_nettype none
module grl_back #(
  parameter int unsigned AW = 24,
  parameter int unsigned RhsW = 40
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            empty_i,
  input  wire grl_pkg::pix_t   pix_i,
  output logic                 pop_o,
  input  wire grl_pkg::thr_t   thr_i,
  input  wire logic [AW-1:0]   area_i,
  input  wire logic [RhsW-1:0] rhs_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output grl_pkg::res_t        res_o
);
  import grl_pkg::*;

  localparam int unsigned SdW  = 20;
  localparam int unsigned HdW  = 17;
  localparam int unsigned CmpW = (CountW + 16 > RhsW) ? CountW + 16 : RhsW;

  logic [SdW-1:0] sdiv_tab [256];
  logic [HdW-1:0] hdiv_tab [256];

  for (genvar i = 0; i < 256; i++) begin : g_tab
    localparam int unsigned Den  = (i == 0) ? 1 : i;
    localparam int unsigned Sdiv = (i == 0) ? 0 : (1044480 + i / 2) / Den;
    localparam int unsigned Hdiv = (i == 0) ? 0 : (122880 + i / 2) / Den;
    assign sdiv_tab[i] = SdW'(Sdiv);
    assign hdiv_tab[i] = HdW'(Hdiv);
  end

  back_state_e          state_q, state_d;
  pix_t                 item_q;
  logic [7:0]           v_q, d_q;
  logic signed [11:0]   sum_q;
  logic [27:0]          sprod_q;
  logic signed [29:0]   hprod_q;
  logic [CountW-1:0]    cnt_q, cnt_d;
  logic                 ov_q, ov_d;
  res_t                 res_q, res_d;

  logic [7:0]           v_c, mn_c, d_c;
  logic signed [11:0]   sum_c;
  logic [27:0]          sprod_c;
  logic signed [29:0]   hprod_c;
  logic [7:0]           s_c;
  logic signed [30:0]   t_c;
  logic signed [9:0]    hs_c, h_c;
  logic                 green_c;
  logic [CountW-1:0]    cnt_new;
  logic [CmpW-1:0]      lhs_c;
  logic                 ld_c, ld_out;

  assign out_valid_o = ov_q;
  assign res_o       = res_q;

  always_comb begin
    v_c  = item_q.blue;
    mn_c = item_q.blue;
    if (item_q.green > v_c) v_c = item_q.green;
    if (item_q.red > v_c) v_c = item_q.red;
    if (item_q.green < mn_c) mn_c = item_q.green;
    if (item_q.red < mn_c) mn_c = item_q.red;
    d_c = v_c - mn_c;
    if (v_c == item_q.red) begin
      sum_c = $signed({4'b0, item_q.green}) - $signed({4'b0, item_q.blue});
    end else if (v_c == item_q.green) begin
      sum_c = $signed({4'b0, item_q.blue}) - $signed({4'b0, item_q.red}) +
              $signed({3'b0, d_c, 1'b0});
    end else begin
      sum_c = $signed({4'b0, item_q.red}) - $signed({4'b0, item_q.green}) +
              $signed({2'b0, d_c, 2'b0});
    end

    sprod_c = 28'({20'b0, d_q} * sdiv_tab[v_q]);
    hprod_c = 30'(sum_q) * 30'($signed({1'b0, hdiv_tab[d_q]}));

    s_c  = 8'((sprod_q + 28'd2048) >> 12);
    t_c  = 31'(hprod_q) + 31'sd2048;
    hs_c = 10'(t_c >>> 12);
    h_c  = (hs_c < 0) ? hs_c + 10'sd180 : hs_c;
    if (d_q == '0) h_c = '0;
    green_c = (h_c >= $signed({2'b0, thr_i.hue_low})) &&
              (h_c <= $signed({2'b0, thr_i.hue_high})) &&
              (s_c >= thr_i.sat_low) && (v_q >= thr_i.val_low);
    cnt_new = (item_q.in_win && green_c && cnt_q != CountMax) ? cnt_q + 1'b1 : cnt_q;
    lhs_c   = CmpW'({cnt_new, 16'b0});

    state_d = state_q;
    pop_o   = 1'b0;
    cnt_d   = cnt_q;
    ld_out  = 1'b0;
    ld_c    = 1'b0;
    res_d   = res_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          ld_c    = 1'b1;
          state_d = BK_CALC;
        end
      end
      BK_CALC: state_d = BK_MUL;
      BK_MUL:  state_d = BK_DONE;
      BK_DONE: begin
        if (!item_q.last) begin
          cnt_d   = cnt_new;
          state_d = BK_IDLE;
        end else if (!ov_q || out_ready_i) begin
          ld_out              = 1'b1;
          res_d.detected      = lhs_c > CmpW'(rhs_i);
          res_d.green_count   = cnt_new;
          res_d.window_pixels = CountW'(area_i);
          cnt_d               = '0;
          state_d             = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
    ov_d = (ov_q && !out_ready_i) || ld_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_c) item_q <= pix_i;
    if (state_q == BK_CALC) begin
      v_q   <= v_c;
      d_q   <= d_c;
      sum_q <= sum_c;
    end
    if (state_q == BK_MUL) begin
      sprod_q <= sprod_c;
      hprod_q <= hprod_c;
    end
    res_q <= res_d;
  end
endmodule
`default_nettype wire

// ----- src/green_light_roi_detector_top.sv -----
// Top level of the green light window detector: config, geometry, front, queue, back.
// Each pixel passes four steps of the back sequencer (pop, min/max, multiply, count),
// so the back takes a new pixel only after the last one is counted; the queue holds up to four pixels.
// The result of a frame appears once its last pixel has passed the queue and these four steps.
// Reset clears column, row, count and queue and loads the default registers.
// Derived window geometry is registered in turn after a configuration write: size, window, area, ratio product.
`default_nettype none
module green_light_roi_detector_top #(
  parameter int unsigned MAX_WIDTH  = grl_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = grl_pkg::DefMaxHeight
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // blue [7:0], green [15:8], red [23:16]
  input  wire logic [23:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // detected [0], green_count [23:1], window_pixels [46:24], zero [47]
  output logic [47:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import grl_pkg::*;

  localparam int unsigned WW   = $clog2(MAX_WIDTH) + 1;
  localparam int unsigned HW   = $clog2(MAX_HEIGHT) + 1;
  localparam int unsigned AW   = WW + HW;
  localparam int unsigned RhsW = AW + RatioW;

  localparam int unsigned W0    = 640;
  localparam int unsigned H0    = 480;
  localparam int unsigned R0    = 1311;
  localparam int unsigned WinX0 = 6 * W0 / 11;
  localparam int unsigned WinH0 = H0 / 3;
  localparam int unsigned Area0 = (W0 - WinX0) * WinH0;

  logic [CfgDimW-1:0] fw_q, fh_q;
  logic [RatioW-1:0]  ratio_q;
  thr_t               thr_q;
  logic [WW-1:0]      w_q;
  logic [HW-1:0]      h_q;
  logic [WW-1:0]      winx_q;
  logic [HW-1:0]      winh_q;
  logic [AW-1:0]      area_q;
  logic [RhsW-1:0]    rhs_q;
  logic [WW-1:0]      w_d;
  logic [HW-1:0]      h_d;
  logic [30:0]        winx_prod;
  logic [26:0]        winh_prod;
  logic               cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q          <= CfgDimW'(W0);
      fh_q          <= CfgDimW'(H0);
      thr_q.hue_low <= 8'd50;
      thr_q.hue_high <= 8'd150;
      thr_q.sat_low <= 8'd100;
      thr_q.val_low <= 8'd100;
      ratio_q       <= RatioW'(R0);
    end else if (cfg_we) begin
      case (reg_idx_e'(cfg_index_i))
        REG_FRAME_WIDTH:  fw_q           <= cfg_data_i[CfgDimW-1:0];
        REG_FRAME_HEIGHT: fh_q           <= cfg_data_i[CfgDimW-1:0];
        REG_HUE_LOW:      thr_q.hue_low  <= cfg_data_i[7:0];
        REG_HUE_HIGH:     thr_q.hue_high <= cfg_data_i[7:0];
        REG_SAT_LOW:      thr_q.sat_low  <= cfg_data_i[7:0];
        REG_VAL_LOW:      thr_q.val_low  <= cfg_data_i[7:0];
        REG_RATIO:        ratio_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_q == '0) w_d = WW'(1);
    else if (32'(fw_q) > MAX_WIDTH) w_d = WW'(MAX_WIDTH);
    else w_d = WW'(fw_q);
    if (fh_q == '0) h_d = HW'(1);
    else if (32'(fh_q) > MAX_HEIGHT) h_d = HW'(MAX_HEIGHT);
    else h_d = HW'(fh_q);
    winx_prod = 31'(w_q) * 31'd6 * 31'd47663;
    winh_prod = 27'(h_q) * 27'd5462;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= WW'(W0);
      h_q    <= HW'(H0);
      winx_q <= WW'(WinX0);
      winh_q <= HW'(WinH0);
      area_q <= AW'(Area0);
      rhs_q  <= RhsW'(Area0 * R0);
    end else begin
      w_q    <= w_d;
      h_q    <= h_d;
      winx_q <= WW'(winx_prod >> 19);
      winh_q <= HW'(winh_prod >> 14);
      area_q <= AW'(w_q - winx_q) * AW'(winh_q);
      rhs_q  <= RhsW'(area_q) * RhsW'(ratio_q);
    end
  end

  logic push, full, pop, empty;
  pix_t pix_in, pix_out;
  res_t res;

  grl_front #(
    .MaxWidth (MAX_WIDTH),
    .MaxHeight(MAX_HEIGHT)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .blue_i  (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .red_i   (s_axis_tdata[23:16]),
    .last_i  (s_axis_tlast),
    .width_i (w_q),
    .win_x_i (winx_q),
    .win_h_i (winh_q),
    .push_o  (push),
    .pix_o   (pix_in),
    .full_i  (full)
  );

  grl_fifo #(
    .Width($bits(pix_t)),
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (pix_in),
    .full_o (full),
    .pop_i  (pop),
    .data_o (pix_out),
    .empty_o(empty)
  );

  grl_back #(
    .AW  (AW),
    .RhsW(RhsW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .pix_i      (pix_out),
    .pop_o      (pop),
    .thr_i      (thr_q),
    .area_i     (area_q),
    .rhs_i      (rhs_q),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {1'b0, res.window_pixels, res.green_count, res.detected};
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for the green light window detector: directed and random pixel frames checked against a predictor.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import grl_pkg::*;

  class roi_scoreboard;
    int unsigned reg_val[8];
    int unsigned col, row, total, pixels_seen;
    res_t expected_q[$];
    int errors;

    function new();
      reg_val[REG_FRAME_WIDTH]  = 640;
      reg_val[REG_FRAME_HEIGHT] = 480;
      reg_val[REG_HUE_LOW]      = 50;
      reg_val[REG_HUE_HIGH]     = 150;
      reg_val[REG_SAT_LOW]      = 100;
      reg_val[REG_VAL_LOW]      = 100;
      reg_val[REG_RATIO]        = 1311;
      col = 0;
      row = 0;
      total = 0;
      pixels_seen = 0;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_e idx, int unsigned value);
      case (idx)
        REG_FRAME_WIDTH, REG_FRAME_HEIGHT: reg_val[idx] = value & 32'hFFF;
        REG_RATIO:                         reg_val[idx] = value & 32'hFFFF;
        REG_SPARE:                         ;
        default:                           reg_val[idx] = value & 32'hFF;
      endcase
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function bit pixel_green(int b, int g, int r);
      int v, mn, d, s, h, sum, t, hdiv;
      v = b;
      mn = b;
      if (g > v) v = g;
      if (r > v) v = r;
      if (g < mn) mn = g;
      if (r < mn) mn = r;
      d = v - mn;
      if (v == 0) s = 0;
      else s = (d * ((255 * 4096 + v / 2) / v) + 2048) >>> 12;
      if (d == 0) begin
        h = 0;
      end else begin
        hdiv = (122880 + d / 2) / d;
        if (v == r) sum = g - b;
        else if (v == g) sum = b - r + 2 * d;
        else sum = r - g + 4 * d;
        t = sum * hdiv + 2048;
        if (t >= 0) h = t / 4096;
        else h = -((-t + 4095) / 4096);
        if (h < 0) h += 180;
      end
      return h >= reg_val[REG_HUE_LOW] && h <= reg_val[REG_HUE_HIGH] &&
             s >= reg_val[REG_SAT_LOW] && v >= reg_val[REG_VAL_LOW];
    endfunction

    function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, bit last);
      int unsigned w, hgt, win_x, win_h, area;
      longint unsigned lhs, rhs;
      res_t res;
      w = clamp_dim(reg_val[REG_FRAME_WIDTH], 2048);
      hgt = clamp_dim(reg_val[REG_FRAME_HEIGHT], 2048);
      win_x = (6 * w) / 11;
      win_h = hgt / 3;
      area = (w - win_x) * win_h;
      pixels_seen++;
      if (col >= win_x && col < w && row < win_h && pixel_green(b, g, r) &&
          total < 32'h7FFFFF)
        total++;
      if (last) begin
        lhs = longint'(total) << 16;
        rhs = longint'(area) * reg_val[REG_RATIO];
        res.detected = lhs > rhs;
        res.green_count = total[CountW-1:0];
        res.window_pixels = area[CountW-1:0];
        expected_q.push_back(res);
        col = 0;
        row = 0;
        total = 0;
      end else if (col + 1 >= w) begin
        col = 0;
        if (row < 2047) row++;
      end else begin
        col++;
      end
    endfunction

    function void check_result(logic [47:0] word);
      res_t exp_res;
      if (expected_q.size() == 0) begin
        $error("Result word with no frame pending: %h", word);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (word[0] !== exp_res.detected) begin
        $error("detected: expected %0d, got %0d", exp_res.detected, word[0]);
        errors++;
      end
      if (word[23:1] !== exp_res.green_count) begin
        $error("green_count: expected %0d, got %0d", exp_res.green_count, word[23:1]);
        errors++;
      end
      if (word[46:24] !== exp_res.window_pixels) begin
        $error("window_pixels: expected %0d, got %0d", exp_res.window_pixels,
               word[46:24]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  roi_scoreboard sb = new();
  bit no_idle = 1'b0;
  int unsigned cycle_count = 0;

  green_light_roi_detector_top DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= no_idle || ($urandom_range(99) >= 11);
  end

  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, bit last);
    while (!no_idle && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r, g, b};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel(b, g, r, last);
  endtask

  task automatic drain_frames();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, int unsigned value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[15:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, value);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_color(bit greenish, bit last);
    logic [7:0] b, g, r;
    b = $urandom_range(255);
    g = $urandom_range(255);
    r = $urandom_range(255);
    if (greenish) begin
      g = $urandom_range(255, 120);
      b = $urandom_range(g);
      r = $urandom_range(g);
    end
    send_pixel(b, g, r, last);
  endtask

  initial begin
    int unsigned w, h, len, n_frames, phase;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    drain_frames();
    write_reg(REG_FRAME_WIDTH, 4);
    write_reg(REG_FRAME_HEIGHT, 3);
    write_reg(REG_HUE_LOW, 0);
    write_reg(REG_HUE_HIGH, 179);
    write_reg(REG_SAT_LOW, 0);
    write_reg(REG_VAL_LOW, 0);
    write_reg(REG_RATIO, 0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd254, 1'b1);
    drain_frames();
    write_reg(REG_HUE_LOW, 179);
    write_reg(REG_HUE_HIGH, 0);
    write_reg(REG_SAT_LOW, 255);
    write_reg(REG_VAL_LOW, 255);
    write_reg(REG_RATIO, 65535);
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    drain_frames();
    write_reg(REG_FRAME_WIDTH, 4095);
    write_reg(REG_FRAME_HEIGHT, 4095);
    write_reg(REG_HUE_LOW, 0);
    write_reg(REG_HUE_HIGH, 179);
    write_reg(REG_SAT_LOW, 0);
    write_reg(REG_VAL_LOW, 0);
    repeat (6) send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);

    phase = 0;
    while (sb.pixels_seen < 720) begin
      drain_frames();
      no_idle = (phase >= 4 && phase < 8);
      w = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(12, 1);
      h = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(9, 1);
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
      write_reg(REG_HUE_LOW, $urandom_range(90));
      write_reg(REG_HUE_HIGH, $urandom_range(179, 30));
      write_reg(REG_SAT_LOW, $urandom_range(3) == 0 ? $urandom_range(255)
                                                    : $urandom_range(120));
      write_reg(REG_VAL_LOW, $urandom_range(3) == 0 ? $urandom_range(255)
                                                    : $urandom_range(120));
      write_reg(REG_RATIO, $urandom_range(3) == 0 ? $urandom_range(65535)
                                                  : $urandom_range(40000));
      n_frames = $urandom_range(4, 1);
      repeat (n_frames) begin
        if (w * h <= 40 && $urandom_range(3) != 0)
          len = w * h + $urandom_range(2) - 1;
        else
          len = $urandom_range(40, 1);
        if (len == 0) len = 1;
        for (int i = 1; i < len; i++) send_color($urandom_range(1), 1'b0);
        send_color($urandom_range(1), $urandom_range(7) != 0);
      end
      phase++;
    end

    drain_frames();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
